[hw/rtl/nnt_pkg.sv]
package nnt_pkg;

  localparam int MaxPoints = 32;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int DistW = 24;
  localparam logic [DistW-1:0] DistMax = '1;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNoStart = 2'd1;
  localparam logic [1:0] StatusDropped = 2'd2;

  typedef struct packed {
    logic [5:0]  point_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [23:0] running_distance;
    logic        tour_end;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic store;
    logic begin_tour;
    logic scan_start;
    logic scan_step;
    logic take_best;
    logic sqrt_start;
    logic sqrt_step;
    logic add_leg;
    logic close_leg;
    logic clear_set;
  } dp_cmd_t;

  typedef struct packed {
    logic          scan_last;
    logic          found;
    logic          sqrt_done;
    logic          start_missing;
  } dp_status_t;

endpackage

[hw/rtl/nnt_if.sv]
interface nnt_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic final_point;
  modport source (output valid, coord_x, coord_y, final_point, input ready);
  modport sink (input valid, coord_x, coord_y, final_point, output ready);
endinterface

interface nnt_out_if;
  logic valid;
  logic ready;
  logic [5:0] point_index;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic [23:0] running_distance;
  logic tour_end;
  logic [1:0] status;
  modport source (output valid, point_index, point_x, point_y, running_distance,
                  tour_end, status, input ready);
  modport sink (input valid, point_index, point_x, point_y, running_distance,
                tour_end, status, output ready);
endinterface

interface nnt_cfg_if;
  logic valid;
  logic ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hw/rtl/nearest_neighbour_tour.sv]
// Greedy nearest-neighbour tour engine. Points are loaded one transfer per cycle until the
// transfer marked final_point; the tour then starts at start_index, visits the nearest
// unvisited point each step and closes at the start (if start_index is not a loaded point,
// one result with StatusNoStart is given instead). Each step scans all 32 store entries,
// drains the distance pipeline, takes the best point, runs a bit-serial square root of 17
// iterations, adds the leg and hands the result over once the previous result has been
// taken. Input and configuration are held off while a tour is under way or a result is
// waiting.
module nearest_neighbour_tour import nnt_pkg::*; (
  input logic clk,
  input logic rst,
  nnt_in_if.sink in_ch,
  nnt_out_if.source out_ch,
  nnt_cfg_if.sink cfg
);

  logic [5:0] start_index;
  dp_cmd_t cmd;
  dp_status_t stat;
  result_t dp_res;
  result_t out_res;
  logic in_fire;
  logic in_ready;
  logic out_valid;

  assign in_fire = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign cfg.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_index <= '0;
    end else if (cfg.valid && cfg.ready) begin
      start_index <= cfg.data;
    end
  end

  nnt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .start_index(start_index),
    .in_x(in_ch.coord_x), .in_y(in_ch.coord_y), .stat(stat), .res(dp_res)
  );

  nnt_controller u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_final(in_ch.final_point),
    .stat(stat), .start_index(start_index), .out_ready(out_ch.ready),
    .dp_res(dp_res),
    .cmd(cmd), .in_ready(in_ready), .out_valid(out_valid), .out_res(out_res)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.point_index = out_res.point_index;
  assign out_ch.point_x = out_res.point_x;
  assign out_ch.point_y = out_res.point_y;
  assign out_ch.running_distance = out_res.running_distance;
  assign out_ch.tour_end = out_res.tour_end;
  assign out_ch.status = out_res.status;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.store && cmd.scan_step)) else $error("store during scan");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid) else $error("result dropped");

endmodule

[hw/rtl/nnt_datapath.sv]
module nnt_datapath import nnt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [5:0]  start_index,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  output dp_status_t  stat,
  output result_t     res
);

  logic [15:0] x_mem [MaxPoints];
  logic [15:0] y_mem [MaxPoints];
  logic [MaxPoints-1:0] visited;
  logic [CntW-1:0] loaded_count;
  logic overflow_seen;
  logic [IdxW-1:0] current_point;
  logic [IdxW-1:0] scan_idx;
  logic [IdxW-1:0] best_idx;
  logic [33:0] best_d;
  logic found;
  logic [DistW-1:0] distance_total;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic signed [15:0] rd_x;
  logic signed [15:0] rd_y;
  logic [IdxW-1:0] rd_idx;
  logic rd_valid;
  logic rd_skip;
  logic [32:0] sq_x;
  logic [32:0] sq_y;
  logic sq_valid;
  logic [IdxW-1:0] sq_idx;
  logic [33:0] d_cand;
  logic [33:0] sq_v;
  logic [17:0] sq_res;
  logic [33:0] sq_rem;
  logic [4:0]  sq_cnt;
  logic sqrt_busy;
  logic [IdxW-1:0] start_pt;
  logic [16:0] dx_abs;
  logic [16:0] dy_abs;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [IdxW-1:0] rd_addr;
  logic [35:0] trial;
  logic [24:0] sum;

  assign start_pt = start_index[IdxW-1:0];
  assign d_cand = {1'b0, sq_x} + {1'b0, sq_y};

  always_comb begin
    if (cmd.take_best) begin
      rd_addr = best_idx;
    end else if (cmd.close_leg || cmd.begin_tour) begin
      rd_addr = start_pt;
    end else begin
      rd_addr = scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !loaded_count[CntW-1]) begin
      x_mem[loaded_count[IdxW-1:0]] <= in_x;
      y_mem[loaded_count[IdxW-1:0]] <= in_y;
    end
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

  assign dx = {rd_x[15], rd_x} - {cur_x[15], cur_x};
  assign dy = {rd_y[15], rd_y} - {cur_y[15], cur_y};
  assign dx_abs = dx[16] ? 17'(-dx) : 17'(dx);
  assign dy_abs = dy[16] ? 17'(-dy) : 17'(dy);
  assign trial = {sq_rem, sq_v[33:32]} - {16'd0, sq_res, 2'b01};
  assign sum = {1'b0, distance_total} + {7'd0, sq_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      loaded_count <= '0;
      overflow_seen <= 1'b0;
      distance_total <= '0;
      rd_valid <= 1'b0;
      sq_valid <= 1'b0;
      found <= 1'b0;
      sqrt_busy <= 1'b0;
      current_point <= '0;
      scan_idx <= '0;
    end else begin
      if (cmd.store) begin
        if (loaded_count[CntW-1]) begin
          overflow_seen <= 1'b1;
        end else begin
          loaded_count <= loaded_count + 1'b1;
        end
      end
      rd_valid <= cmd.scan_step;
      rd_idx <= scan_idx;
      rd_skip <= visited[scan_idx] || ({1'b0, scan_idx} >= loaded_count);
      sq_valid <= rd_valid && !rd_skip;
      sq_idx <= rd_idx;
      sq_x <= dx_abs * dx_abs;
      sq_y <= dy_abs * dy_abs;
      if (cmd.scan_start) begin
        scan_idx <= '0;
        found <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (sq_valid && (!found || d_cand < best_d)) begin
        found <= 1'b1;
        best_d <= d_cand;
        best_idx <= sq_idx;
      end
      if (cmd.begin_tour) begin
        visited <= MaxPoints'(1) << start_pt;
        current_point <= start_pt;
        distance_total <= '0;
      end
      if (cmd.take_best) begin
        visited[best_idx] <= 1'b1;
        current_point <= best_idx;
      end
      if (cmd.sqrt_start) begin
        sq_v <= cmd.close_leg ? {1'b0, sq_x} + {1'b0, sq_y} : best_d;
        sq_res <= '0;
        sq_rem <= '0;
        sq_cnt <= '0;
        sqrt_busy <= 1'b1;
      end else if (cmd.sqrt_step && sqrt_busy) begin
        sq_v <= {sq_v[31:0], 2'b00};
        if (!trial[35]) begin
          sq_rem <= trial[33:0];
          sq_res <= {sq_res[16:0], 1'b1};
        end else begin
          sq_rem <= {sq_rem[31:0], sq_v[33:32]};
          sq_res <= {sq_res[16:0], 1'b0};
        end
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_cnt == 5'd16) begin
          sqrt_busy <= 1'b0;
        end
      end
      if (cmd.add_leg) begin
        distance_total <= sum[24] ? DistMax : sum[23:0];
      end
      if (cmd.clear_set) begin
        visited <= '0;
        loaded_count <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_tour || cmd.take_best) begin
      cur_x <= x_mem[rd_addr];
      cur_y <= y_mem[rd_addr];
    end
  end

  assign stat.scan_last = (scan_idx == IdxW'(MaxPoints - 1));
  assign stat.found = found;
  assign stat.sqrt_done = !sqrt_busy;
  assign stat.start_missing = ({1'b0, start_index} >= 7'(loaded_count));

  assign res.point_index = cmd.close_leg ? start_index : 6'(current_point);
  assign res.point_x = cmd.close_leg ? rd_x : cur_x;
  assign res.point_y = cmd.close_leg ? rd_y : cur_y;
  assign res.running_distance = distance_total;
  assign res.tour_end = cmd.close_leg;
  assign res.status = overflow_seen ? StatusDropped : StatusOk;

endmodule

[hw/rtl/nnt_controller.sv]
module nnt_controller import nnt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic       in_final,
  input  dp_status_t stat,
  input  logic [5:0] start_index,
  input  logic       out_ready,
  input  result_t    dp_res,
  output dp_cmd_t    cmd,
  output logic       in_ready,
  output logic       out_valid,
  output result_t    out_res
);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SCheck = 4'd1;
  localparam logic [3:0] SStartRd = 4'd2;
  localparam logic [3:0] SStartOut = 4'd3;
  localparam logic [3:0] SScan = 4'd4;
  localparam logic [3:0] SDrain = 4'd5;
  localparam logic [3:0] STake = 4'd6;
  localparam logic [3:0] SSqrt = 4'd7;
  localparam logic [3:0] SStepOut = 4'd8;
  localparam logic [3:0] SCloseRd = 4'd9;
  localparam logic [3:0] SCloseSq = 4'd10;
  localparam logic [3:0] SCloseSqrt = 4'd11;
  localparam logic [3:0] SCloseOut = 4'd12;
  localparam logic [3:0] SWait = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] drain;

  assign in_ready = (state == SIdle) && !out_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      SIdle: begin
        cmd.store = in_fire;
        if (in_fire && in_final) begin
          state_next = SCheck;
        end
      end
      SCheck: begin
        if (stat.start_missing) begin
          cmd.clear_set = 1'b1;
          state_next = SWait;
        end else begin
          cmd.begin_tour = 1'b1;
          state_next = SStartRd;
        end
      end
      SStartRd: state_next = SStartOut;
      SStartOut: begin
        if (!out_valid) begin
          cmd.scan_start = 1'b1;
          state_next = SScan;
        end
      end
      SScan: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = SDrain;
        end
      end
      SDrain: begin
        if (drain == 3'd3) begin
          state_next = stat.found ? STake : SCloseRd;
        end
      end
      STake: begin
        cmd.take_best = 1'b1;
        cmd.sqrt_start = 1'b1;
        state_next = SSqrt;
      end
      SSqrt: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_done) begin
          cmd.sqrt_step = 1'b0;
          cmd.add_leg = 1'b1;
          state_next = SStepOut;
        end
      end
      SStepOut: begin
        if (!out_valid) begin
          cmd.scan_start = 1'b1;
          state_next = SScan;
        end
      end
      SCloseRd: begin
        cmd.close_leg = 1'b1;
        state_next = SCloseSq;
      end
      SCloseSq: begin
        cmd.close_leg = 1'b1;
        if (drain == 3'd2) begin
          cmd.sqrt_start = 1'b1;
          state_next = SCloseSqrt;
        end
      end
      SCloseSqrt: begin
        cmd.close_leg = 1'b1;
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_done) begin
          cmd.sqrt_step = 1'b0;
          cmd.add_leg = 1'b1;
          state_next = SCloseOut;
        end
      end
      SCloseOut: begin
        cmd.close_leg = 1'b1;
        if (!out_valid) begin
          cmd.clear_set = 1'b1;
          state_next = SWait;
        end
      end
      SWait: begin
        if (!out_valid) begin
          state_next = SIdle;
        end
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
      drain <= '0;
    end else begin
      state <= state_next;
      if (state == SDrain || state == SCloseSq) begin
        drain <= drain + 1'b1;
      end else begin
        drain <= '0;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == SCheck && stat.start_missing) begin
        out_valid <= 1'b1;
        out_res.point_index <= start_index;
        out_res.point_x <= '0;
        out_res.point_y <= '0;
        out_res.running_distance <= '0;
        out_res.tour_end <= 1'b1;
        out_res.status <= StatusNoStart;
      end
      if ((state == SStartOut || state == SStepOut || state == SCloseOut) && !out_valid) begin
        out_valid <= 1'b1;
        out_res <= dp_res;
      end
    end
  end

endmodule

[tb/sv/nearest_neighbour_tour_test.sv]
module nearest_neighbour_tour_test;
  import nnt_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nnt_in_if in_ch();
  nnt_out_if out_ch();
  nnt_cfg_if cfg();

  nearest_neighbour_tour i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg(cfg.sink)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  result_t tour_results[$];
  int error_count = 0;
  bit quiet = 1'b0;
  int sink_stall = 0;
  int idle_cycles = 0;

  logic [5:0] start_point = '0;
  logic signed [15:0] set_x[MaxPoints];
  logic signed [15:0] set_y[MaxPoints];
  int set_count = 0;
  bit set_dropped = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.final_point = 1'b0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
  end

  task automatic report(input string what, input int got, input int want);
    error_count++;
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
  endtask

  function automatic longint unsigned leg_squared(input int a, input int b);
    longint dx, dy;
    dx = longint'(set_x[a]) - longint'(set_x[b]);
    dy = longint'(set_y[a]) - longint'(set_y[b]);
    return longint'(dx * dx + dy * dy);
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      b = r | (64'd1 << k);
      if (b * b <= v) r = b;
    end
    return r;
  endfunction

  function automatic logic [23:0] add_length(input logic [23:0] total, input int a,
                                             input int b);
    longint unsigned t;
    t = longint'(total) + floor_root(leg_squared(a, b));
    return (t > DistMax) ? DistMax : t[23:0];
  endfunction

  task automatic predict_tour();
    result_t r;
    bit seen[MaxPoints];
    int here, best_idx;
    longint unsigned best, d;
    logic [23:0] total;
    logic [1:0] st;
    if (int'(start_point) >= set_count) begin
      r = '{point_index: start_point, point_x: '0, point_y: '0, running_distance: '0,
            tour_end: 1'b1, status: StatusNoStart};
      tour_results.push_back(r);
    end else begin
      st = set_dropped ? StatusDropped : StatusOk;
      foreach (seen[i]) seen[i] = 1'b0;
      here = int'(start_point);
      seen[here] = 1'b1;
      total = '0;
      r = '{point_index: 6'(here), point_x: set_x[here], point_y: set_y[here],
            running_distance: total, tour_end: 1'b0, status: st};
      tour_results.push_back(r);
      for (int s = 1; s < set_count; s++) begin
        best_idx = -1;
        best = 0;
        for (int i = 0; i < set_count; i++) begin
          if (!seen[i]) begin
            d = leg_squared(here, i);
            if (best_idx < 0 || d < best) begin
              best = d;
              best_idx = i;
            end
          end
        end
        total = add_length(total, here, best_idx);
        seen[best_idx] = 1'b1;
        here = best_idx;
        r = '{point_index: 6'(here), point_x: set_x[here], point_y: set_y[here],
              running_distance: total, tour_end: 1'b0, status: st};
        tour_results.push_back(r);
      end
      total = add_length(total, here, int'(start_point));
      r = '{point_index: start_point, point_x: set_x[start_point],
            point_y: set_y[start_point], running_distance: total, tour_end: 1'b1,
            status: st};
      tour_results.push_back(r);
    end
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input bit last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.coord_x = x;
    in_ch.coord_y = y;
    in_ch.final_point = last;
    do @(posedge clk); while (!in_ch.ready);
    if (set_count < MaxPoints) begin
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) predict_tour();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic set_start(input logic [5:0] v);
    while (tour_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg.valid = 1'b1;
    cfg.data = v;
    do @(posedge clk); while (!cfg.ready);
    start_point = v;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic send_random_set(input int n, input int spread);
    for (int i = 0; i < n; i++) begin
      if (spread == 0)
        send_point(16'($urandom), 16'($urandom), i == n - 1);
      else
        send_point(16'($signed($urandom_range(0, 2 * spread)) - spread),
                   16'($signed($urandom_range(0, 2 * spread)) - spread), i == n - 1);
    end
  endtask

  task automatic test_directed();
    set_start(6'd0);
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd0, 1'b0);
    send_point(-16'sd1, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd1, 1'b0);
    send_point(16'sd0, -16'sd1, 1'b1);
    set_start(6'd63);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(-16'sd5, 16'sd5, 1'b1);
    set_start(6'd2);
    send_point(16'sd3, 16'sd4, 1'b1);
  endtask

  task automatic test_overflow();
    set_start(6'd31);
    send_random_set(35, 0);
    set_start(6'd0);
    send_random_set(33, 100);
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 420) begin
      if ($urandom_range(0, 3) == 0) set_start(6'($urandom_range(0, 9)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 8);
      if (sent > 360) quiet = 1'b1;
      case ($urandom_range(0, 2))
        0: send_random_set(n, 0);
        1: send_random_set(n, 3);
        default: send_random_set(n, 1000);
      endcase
      sent += n;
    end
  endtask

  always @(negedge clk) begin
    if (sink_stall > 0) begin
      out_ch.ready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      out_ch.ready <= 1'b0;
      sink_stall <= $urandom_range(0, 5);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (tour_results.size() == 0) begin
        report("unexpected result index", int'(out_ch.point_index), -1);
      end else begin
        want = tour_results.pop_front();
        if (out_ch.point_index !== want.point_index)
          report("point_index", int'(out_ch.point_index), int'(want.point_index));
        if (out_ch.point_x !== want.point_x)
          report("point_x", int'(out_ch.point_x), int'(want.point_x));
        if (out_ch.point_y !== want.point_y)
          report("point_y", int'(out_ch.point_y), int'(want.point_y));
        if (out_ch.running_distance !== want.running_distance)
          report("running_distance", int'(out_ch.running_distance),
                 int'(want.running_distance));
        if (out_ch.tour_end !== want.tour_end)
          report("tour_end", int'(out_ch.tour_end), int'(want.tour_end));
        if (out_ch.status !== want.status)
          report("status", int'(out_ch.status), int'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_overflow();
    test_random();
    while (tour_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[nearest_neighbour_tour.f]
hw/rtl/nnt_pkg.sv
hw/rtl/nnt_if.sv
hw/rtl/nnt_datapath.sv
hw/rtl/nnt_controller.sv
hw/rtl/nearest_neighbour_tour.sv
tb/sv/nearest_neighbour_tour_test.sv
